// ----- hdl/tprr_pkg.sv -----
// Package for the two-pool round-robin element mapper: widths, codes, state type
// and the pool count clamp. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package tprr_pkg;

	// number of processing elements in the system
	localparam int NUM_PE = 16;

	// widths fixed by the request and response fields
	localparam int MASK_W   = 16;
	localparam int SIZE_W   = 32;
	localparam int PE_W     = 4;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int TBL_DEPTH = 16;

	// largest pool size honored; larger count registers saturate here
	localparam logic [COUNT_W-1:0] POOL_MAX = COUNT_W'(16);

	// elements at or above this number never qualify
	localparam int REACH = (NUM_PE < TBL_DEPTH) ? NUM_PE : TBL_DEPTH;
	localparam logic [COUNT_W-1:0] ELEM_REACH = COUNT_W'(REACH);

	// request action codes
	localparam logic ACT_MAP   = 1'b0;
	localparam logic ACT_LIMIT = 1'b1;

	// response status codes
	typedef enum logic [1:0] {
		STAT_ASSIGNED = 2'd0,
		STAT_RUNNING  = 2'd1,
		STAT_NO_PE    = 2'd2,
		STAT_LIMIT    = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IO_COUNT      = 2'd0,
		CFG_COMPUTE_COUNT = 2'd1,
		CFG_ACTIVE_MASK   = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_REDUCE,
		S_SCAN,
		S_RESULT
	} state_t;

	// saturate a pool count register at the pool maximum
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
		clamp_count = (n > POOL_MAX) ? POOL_MAX : n;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/tprr_if.sv -----
// Request and response channel interfaces of the element mapper.
// Depends on tprr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// request channel: map a task or write one allocation limit
interface tprr_req_if;
	import tprr_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic                is_normal;
	logic                already_running;
	logic [MASK_W-1:0]   exec_mask;
	logic [SIZE_W-1:0]   alloc_size;
	logic [PE_W-1:0]     limit_index;
	logic [SIZE_W-1:0]   limit_value;

	modport source (
		output valid, action, is_normal, already_running, exec_mask, alloc_size,
		       limit_index, limit_value,
		input  ready
	);
	modport sink (
		input  valid, action, is_normal, already_running, exec_mask, alloc_size,
		       limit_index, limit_value,
		output ready
	);
endinterface

// response channel: status and chosen element
interface tprr_rsp_if;
	import tprr_pkg::*;

	logic            valid;
	logic            ready;
	logic [1:0]      status;
	logic [PE_W-1:0] chosen_pe;

	modport source (output valid, status, chosen_pe, input ready);
	modport sink (input valid, status, chosen_pe, output ready);
endinterface

`default_nettype wire

// ----- hdl/two_pool_round_robin_pe_mapper_core.sv -----
// Two-pool round-robin processing-element mapper: sequencer, limit table, cursors.
// Depends on tprr_pkg and the channel interfaces in tprr_if.sv.
//
// One request at a time. A limit write, a running task or a special task goes from
// acceptance straight to the result state and from there into the response register.
// A normal task is checked one candidate element per cycle by a single qualify unit
// (mask bits and one 32-bit compare against the limit table): per pool, a start
// state loads the cursor, a reduce state folds it into the pool by repeated
// compare-subtract, and a scan state then checks up to pool-size candidates. An
// empty pool passes through its start state only. Requests are taken again while
// a finished response waits in the output register. Config writes are taken at
// any time and must only happen while no request is open.
`timescale 1ns / 1ps
`default_nettype none

module two_pool_round_robin_pe_mapper_core
	import tprr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tprr_req_if.sink                  req,
	tprr_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [COUNT_W-1:0] io_count_q;
	logic [COUNT_W-1:0] cc_count_q;
	logic [MASK_W-1:0]  active_mask_q;

	// persistent state
	logic [PE_W-1:0]    io_cursor_q;
	logic [PE_W-1:0]    cc_cursor_q;
	logic [SIZE_W-1:0]  alloc_limits_q [TBL_DEPTH];

	// working registers of the current request
	logic [MASK_W-1:0]  exec_q;
	logic [SIZE_W-1:0]  size_q;
	logic               pool_io_q;
	logic [PE_W-1:0]    idx_q;
	logic [COUNT_W-1:0] k_q;
	status_t            res_status_q;
	logic [PE_W-1:0]    res_pe_q;

	// response register
	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [PE_W-1:0]    rsp_pe_q;

	// shared qualify unit and scan helpers
	logic [COUNT_W-1:0] cnt_io;
	logic [COUNT_W-1:0] cnt_cc;
	logic [COUNT_W-1:0] pool_cnt;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] elem;
	logic [PE_W-1:0]    elem_lo;
	logic               qual;
	logic               last;
	logic [PE_W-1:0]    idx_next;
	logic               idx_over;
	logic               accept;
	logic               rsp_free;
	logic               direct;

	assign cnt_io   = clamp_count(io_count_q);
	assign cnt_cc   = clamp_count(cc_count_q);
	assign pool_cnt = pool_io_q ? cnt_io : cnt_cc;
	assign base     = pool_io_q ? '0 : cnt_io;
	assign elem     = base + {1'b0, idx_q};
	assign elem_lo  = elem[PE_W-1:0];
	assign qual     = (elem < ELEM_REACH) && active_mask_q[elem_lo] && exec_q[elem_lo]
	                  && (size_q < alloc_limits_q[elem_lo]);
	assign last     = (k_q + COUNT_W'(1)) == pool_cnt;
	assign idx_next = (({1'b0, idx_q} + COUNT_W'(1)) == pool_cnt) ? '0 : idx_q + PE_W'(1);
	assign idx_over = {1'b0, idx_q} >= pool_cnt;

	assign accept   = req.valid && req.ready;
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign direct   = (req.action == ACT_LIMIT) || req.already_running || !req.is_normal;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.chosen_pe = rsp_pe_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = direct ? S_RESULT : S_START;
				end
			end
			S_START: begin
				if (pool_cnt == '0) begin
					state_d = pool_io_q ? S_RESULT : S_START;
				end else begin
					state_d = S_REDUCE;
				end
			end
			S_REDUCE: begin
				state_d = idx_over ? S_REDUCE : S_SCAN;
			end
			S_SCAN: begin
				if (qual) begin
					state_d = S_RESULT;
				end else if (last) begin
					state_d = pool_io_q ? S_RESULT : S_START;
				end
			end
			S_RESULT: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_count_q    <= COUNT_W'(1);
			cc_count_q    <= '0;
			active_mask_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_IO_COUNT:      io_count_q    <= cfg_data[COUNT_W-1:0];
				CFG_COMPUTE_COUNT: cc_count_q    <= cfg_data[COUNT_W-1:0];
				CFG_ACTIVE_MASK:   active_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// limit table and pool cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			io_cursor_q <= '0;
			cc_cursor_q <= '0;
			for (int i = 0; i < TBL_DEPTH; i++) begin
				alloc_limits_q[i] <= '0;
			end
		end else begin
			if (accept && req.action == ACT_LIMIT) begin
				alloc_limits_q[req.limit_index] <= req.limit_value;
			end
			if (state_q == S_SCAN && qual) begin
				if (pool_io_q) begin
					io_cursor_q <= idx_next;
				end else begin
					cc_cursor_q <= idx_next;
				end
			end
		end
	end

	// working registers of the search
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					exec_q    <= req.exec_mask;
					size_q    <= req.alloc_size;
					pool_io_q <= 1'b0;
					res_pe_q  <= '0;
					priority if (req.action == ACT_LIMIT) begin
						res_status_q <= STAT_LIMIT;
					end else if (req.already_running) begin
						res_status_q <= STAT_RUNNING;
					end else begin
						res_status_q <= STAT_ASSIGNED;
					end
				end
			end
			S_START: begin
				if (pool_cnt == '0) begin
					if (pool_io_q) begin
						res_status_q <= STAT_NO_PE;
						res_pe_q     <= '0;
					end
					pool_io_q <= 1'b1;
				end else begin
					idx_q <= pool_io_q ? io_cursor_q : cc_cursor_q;
					k_q   <= '0;
				end
			end
			S_REDUCE: begin
				// fold the cursor into the pool, one subtract per cycle
				if (idx_over) begin
					idx_q <= PE_W'({1'b0, idx_q} - pool_cnt);
				end
			end
			S_SCAN: begin
				if (qual) begin
					res_status_q <= STAT_ASSIGNED;
					res_pe_q     <= elem_lo;
				end else if (last) begin
					if (pool_io_q) begin
						res_status_q <= STAT_NO_PE;
						res_pe_q     <= '0;
					end
					pool_io_q <= 1'b1;
				end else begin
					idx_q <= idx_next;
					k_q   <= k_q + COUNT_W'(1);
				end
			end
			S_RESULT: ;
			default: ;
		endcase
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && rsp_free) begin
			rsp_status_q <= res_status_q;
			rsp_pe_q     <= res_pe_q;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tprr_checker.sv -----
// Port-level checks of the element mapper, bound to its top level.
// Depends on tprr_pkg and two_pool_round_robin_pe_mapper_core.
`timescale 1ns / 1ps
`default_nettype none

module tprr_checker
	import tprr_pkg::*;
(
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_ready,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire logic [1:0]      rsp_status,
	input wire logic [PE_W-1:0] rsp_chosen_pe
);

	// a stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
		&& $stable(rsp_chosen_pe))
		else $error("response changed while stalled");

	// no element is reported unless the task was assigned
	a_pe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_ASSIGNED |-> rsp_chosen_pe == '0)
		else $error("chosen element set on a non-assigned response");

	// the block works on one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// assigned elements lie within the system
	a_pe_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_ASSIGNED |-> {1'b0, rsp_chosen_pe} < ELEM_REACH)
		else $error("assigned element out of reach");

endmodule

bind two_pool_round_robin_pe_mapper_core tprr_checker u_tprr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_chosen_pe (rsp.chosen_pe)
);

`default_nettype wire
